// File: src/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Token kinds, character codes and keyword tables for the byte stream
// tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

  typedef enum logic [4:0] {
    TK_WRITELN,
    TK_IF,
    TK_ELSE,
    TK_IDENT,
    TK_NIDENT,
    TK_SIDENT,
    TK_ICONST,
    TK_RCONST,
    TK_SCONST,
    TK_PLUS,
    TK_MINUS,
    TK_MULT,
    TK_DIV,
    TK_EXPONENT,
    TK_ASSOP,
    TK_LPAREN,
    TK_RPAREN,
    TK_LBRACES,
    TK_RBRACES,
    TK_NEQ,
    TK_NGTHAN,
    TK_NLTHAN,
    TK_CAT,
    TK_SREPEAT,
    TK_SEQ,
    TK_SLTHAN,
    TK_SGTHAN,
    TK_COMMA,
    TK_SEMICOL,
    TK_ERR,
    TK_DONE
  } tok_kind_e;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_EQ     = 8'h3d;

  // register index of start_line
  localparam logic REG_START_LINE = 1'b0;

  // dash lookahead letters
  localparam logic [1:0] DL_E = 2'd0;
  localparam logic [1:0] DL_G = 2'd1;
  localparam logic [1:0] DL_L = 2'd2;

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    unique case (k)
      2'd0: len = 3'd7;
      2'd1: len = 3'd2;
      2'd2: len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // keyword k still matches with byte c at position idx
  function automatic logic kw_ok(input logic [1:0] k, input logic [2:0] idx,
                                 input logic [7:0] c);
    logic [63:0] txt;
    logic [7:0]  ch;
    unique case (k)
      2'd0: txt = {"writeln", 8'h00};
      2'd1: txt = {"if", 48'h0};
      2'd2: txt = {"else", 32'h0};
      default: txt = 64'h0;
    endcase
    ch = txt[8*(7-int'(idx)) +: 8];
    return (idx < kw_len(k)) && (c == ch);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
  endfunction

endpackage

// File: src/byte_stream_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// byte_stream_tokenizer_unit
// Scans source text one byte per transaction and emits tokens with kind,
// line, start offset and length through a small result queue.
//
//   channel  dir  handshake            payload
//   input    in   in_valid/in_ready    char_byte, end_of_input
//   result   out  out_valid/out_ready  token_kind, line_number, start_offset,
//                                      lexeme_length, last_of_run
//   config   in   apb write/read       start_line at address 0
//
// a byte is scanned in the cycle it is accepted; its tokens land in a
// four-entry result queue on the same edge
// one byte per cycle while each byte yields at most one token and results are
// taken as they come; a byte that yields two tokens queues both, and they leave one at a time
// in_ready drops while fewer than two queue entries are free
// asynchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module byte_stream_tokenizer_unit #(
  parameter int LINE_BITS   = 24,
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             char_byte_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [4:0]             token_kind_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [31:0]            start_offset_o,
  output logic [LENGTH_BITS-1:0] lexeme_length_o,
  output logic                   last_of_run_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [3:0] M_START   = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_STRING  = 4'd2;
  localparam logic [3:0] M_INT     = 4'd3;
  localparam logic [3:0] M_REAL    = 4'd4;
  localparam logic [3:0] M_COMMENT = 4'd5;
  localparam logic [3:0] M_STAR    = 4'd6;
  localparam logic [3:0] M_EQ      = 4'd7;
  localparam logic [3:0] M_DASH    = 4'd8;
  localparam logic [3:0] M_DASH2   = 4'd9;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [32:0] LINE_TOP = (33'd1 << LINE_BITS) - 33'd1;

  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef struct packed {
    bst_pkg::tok_kind_e kind;
    line_t              line;
    logic [31:0]        start;
    len_t               len;
    logic               last;
  } res_t;

  // state
  logic        fresh_q, fresh_d;
  logic [3:0]  mode_q, mode_d;
  line_t       line_q, line_d;
  logic [31:0] bpos_q, bpos_d;
  logic [31:0] tstart_q, tstart_d;
  len_t        tlen_q, tlen_d;
  logic [2:0]  kwf_q, kwf_d;
  logic [1:0]  pfx_q, pfx_d;
  logic [1:0]  dash_q, dash_d;
  logic [15:0] start_line_q;

  // result queue
  res_t             q_mem [QDEPTH];
  logic [QPW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;

  logic       in_acc, out_acc;
  logic [7:0] c, cu;
  line_t      line0, linc;
  logic [31:0] pos;
  len_t       lenp;
  logic       c_ident;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bst_pkg::REG_START_LINE) ? {16'h0, start_line_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_line_q <= 16'd1;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == bst_pkg::REG_START_LINE)) begin
      start_line_q <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // common terms
  // ---------------------------------------------------------------------------
  assign in_ready_o = (cnt_q <= QCW'(QDEPTH - 2));
  assign in_acc     = in_valid_i && in_ready_o;
  assign c          = char_byte_i;
  assign cu         = bst_pkg::to_upper(c);
  assign c_ident    = bst_pkg::is_letter(c) || bst_pkg::is_digit(c) || (c == bst_pkg::CH_UNDER);

  always_comb begin
    logic [32:0] sl_ext;
    sl_ext = 33'(start_line_q);
    if (fresh_q) begin
      line0 = (sl_ext > LINE_TOP) ? LINE_TOP[LINE_BITS-1:0] : sl_ext[LINE_BITS-1:0];
    end else begin
      line0 = line_q;
    end
  end

  assign linc = (line0 == '1) ? line0 : line0 + line_t'(1);
  assign pos  = fresh_q ? 32'h0 : bpos_q;
  assign lenp = (tlen_q == '1) ? tlen_q : tlen_q + len_t'(1);

  // ---------------------------------------------------------------------------
  // pending token as it stands (flush and finish-on-delimiter)
  // ---------------------------------------------------------------------------
  logic               fl_emit;
  bst_pkg::tok_kind_e fl_kind;
  logic [31:0]        fl_start;
  len_t               fl_len;
  bst_pkg::tok_kind_e id_kind;

  always_comb begin
    id_kind = (pfx_q == 2'd1) ? bst_pkg::TK_NIDENT :
              (pfx_q == 2'd2) ? bst_pkg::TK_SIDENT : bst_pkg::TK_IDENT;
    priority if (kwf_q[0] && (tlen_q == len_t'(bst_pkg::kw_len(2'd0)))) begin
      id_kind = bst_pkg::TK_WRITELN;
    end else if (kwf_q[1] && (tlen_q == len_t'(bst_pkg::kw_len(2'd1)))) begin
      id_kind = bst_pkg::TK_IF;
    end else if (kwf_q[2] && (tlen_q == len_t'(bst_pkg::kw_len(2'd2)))) begin
      id_kind = bst_pkg::TK_ELSE;
    end else begin
    end
  end

  always_comb begin
    fl_emit  = 1'b1;
    fl_kind  = bst_pkg::TK_ERR;
    fl_start = tstart_q;
    fl_len   = tlen_q;
    unique case (mode_q)
      M_IDENT:  fl_kind = id_kind;
      M_STRING: begin
        fl_start = tstart_q - 32'd1;
        fl_len   = lenp;
      end
      M_INT:    fl_kind = bst_pkg::TK_ICONST;
      M_REAL:   fl_kind = bst_pkg::TK_RCONST;
      M_STAR: begin
        fl_kind = bst_pkg::TK_MULT;
        fl_len  = len_t'(1);
      end
      M_EQ: begin
        fl_kind = bst_pkg::TK_ASSOP;
        fl_len  = len_t'(1);
      end
      M_DASH: begin
        fl_kind = bst_pkg::TK_MINUS;
        fl_len  = len_t'(1);
      end
      M_DASH2: begin
        fl_kind = bst_pkg::TK_MINUS;
        fl_len  = len_t'(2);
      end
      default:  fl_emit = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // byte seen from start mode
  // ---------------------------------------------------------------------------
  logic               s_emit, s_inc, s_keep;
  bst_pkg::tok_kind_e s_kind;
  logic [3:0]         s_mode;
  logic [31:0]        s_tstart;
  len_t               s_tlen;
  logic [2:0]         s_kwf;
  logic [1:0]         s_pfx;

  always_comb begin
    s_emit   = 1'b0;
    s_inc    = 1'b0;
    s_keep   = 1'b0;
    s_kind   = bst_pkg::TK_ERR;
    s_mode   = M_START;
    s_tstart = pos;
    s_tlen   = len_t'(1);
    s_kwf    = kwf_q;
    s_pfx    = pfx_q;
    priority if (c == bst_pkg::CH_NL) begin
      s_keep = 1'b1;
      s_inc  = 1'b1;
    end else if ((c == bst_pkg::CH_SPACE) || (c == bst_pkg::CH_TAB)) begin
      s_keep = 1'b1;
    end else if (c == bst_pkg::CH_QUOTE) begin
      s_mode   = M_STRING;
      s_tstart = pos + 32'd1;
      s_tlen   = '0;
    end else if (c == bst_pkg::CH_HASH) begin
      s_mode = M_COMMENT;
    end else if (bst_pkg::is_digit(c)) begin
      s_mode = M_INT;
    end else if (bst_pkg::is_letter(c) || (c == bst_pkg::CH_UNDER)
                 || (c == bst_pkg::CH_DOLLAR) || (c == bst_pkg::CH_AT)) begin
      s_mode = M_IDENT;
      s_pfx  = (c == bst_pkg::CH_DOLLAR) ? 2'd1 : ((c == bst_pkg::CH_AT) ? 2'd2 : 2'd0);
      s_kwf  = {bst_pkg::kw_ok(2'd2, 3'd0, c), bst_pkg::kw_ok(2'd1, 3'd0, c),
                bst_pkg::kw_ok(2'd0, 3'd0, c)};
    end else if (c == bst_pkg::CH_DASH) begin
      s_mode = M_DASH;
    end else if (c == bst_pkg::CH_STAR) begin
      s_mode = M_STAR;
    end else if (c == bst_pkg::CH_EQ) begin
      s_mode = M_EQ;
    end else begin
      s_emit = 1'b1;
      unique case (c)
        "+":     s_kind = bst_pkg::TK_PLUS;
        "/":     s_kind = bst_pkg::TK_DIV;
        "^":     s_kind = bst_pkg::TK_EXPONENT;
        ">":     s_kind = bst_pkg::TK_NGTHAN;
        "<":     s_kind = bst_pkg::TK_NLTHAN;
        ".":     s_kind = bst_pkg::TK_CAT;
        "{":     s_kind = bst_pkg::TK_LBRACES;
        "}":     s_kind = bst_pkg::TK_RBRACES;
        "(":     s_kind = bst_pkg::TK_LPAREN;
        ")":     s_kind = bst_pkg::TK_RPAREN;
        ",":     s_kind = bst_pkg::TK_COMMA;
        ";":     s_kind = bst_pkg::TK_SEMICOL;
        default: begin
          s_kind = bst_pkg::TK_ERR;
          s_inc  = 1'b1;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // byte seen from the current mode
  // ---------------------------------------------------------------------------
  logic               a_emit, a_inc, redo;
  bst_pkg::tok_kind_e a_kind;
  logic [31:0]        a_start;
  len_t               a_len;
  logic [3:0]         a_mode;
  len_t               a_tlen;
  logic [2:0]         a_kwf;
  logic [1:0]         a_dash;
  logic               kw_short;

  assign kw_short = (tlen_q < len_t'(8));

  always_comb begin
    a_emit  = 1'b0;
    a_inc   = 1'b0;
    redo    = 1'b0;
    a_kind  = fl_kind;
    a_start = tstart_q;
    a_len   = tlen_q;
    a_mode  = mode_q;
    a_tlen  = tlen_q;
    a_kwf   = kwf_q;
    a_dash  = dash_q;
    unique case (mode_q)
      M_IDENT: begin
        if (c_ident) begin
          a_tlen = lenp;
          for (int k = 0; k < 3; k++) begin
            a_kwf[k] = kwf_q[k] && kw_short && bst_pkg::kw_ok(2'(k), tlen_q[2:0], c);
          end
        end else begin
          redo = 1'b1;
        end
      end
      M_STRING: begin
        if (c == bst_pkg::CH_QUOTE) begin
          a_emit = 1'b1;
          a_kind = bst_pkg::TK_SCONST;
          a_mode = M_START;
        end else if (c == bst_pkg::CH_NL) begin
          a_emit  = 1'b1;
          a_inc   = 1'b1;
          a_kind  = bst_pkg::TK_ERR;
          a_start = tstart_q - 32'd1;
          a_len   = lenp;
          a_mode  = M_START;
        end else begin
          a_tlen = lenp;
        end
      end
      M_INT: begin
        if (bst_pkg::is_digit(c)) begin
          a_tlen = lenp;
        end else if (c == bst_pkg::CH_DOT) begin
          a_tlen = lenp;
          a_mode = M_REAL;
        end else begin
          redo = 1'b1;
        end
      end
      M_REAL: begin
        if (bst_pkg::is_digit(c)) begin
          a_tlen = lenp;
        end else if (c == bst_pkg::CH_DOT) begin
          a_tlen = lenp;
          a_emit = 1'b1;
          a_inc  = 1'b1;
          a_kind = bst_pkg::TK_ERR;
          a_len  = lenp;
          a_mode = M_START;
        end else begin
          redo = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == bst_pkg::CH_NL) begin
          a_inc  = 1'b1;
          a_mode = M_START;
        end
      end
      M_STAR: begin
        if (c == bst_pkg::CH_STAR) begin
          a_emit = 1'b1;
          a_kind = bst_pkg::TK_SREPEAT;
          a_len  = len_t'(2);
          a_mode = M_START;
        end else begin
          redo = 1'b1;
        end
      end
      M_EQ: begin
        if (c == bst_pkg::CH_EQ) begin
          a_emit = 1'b1;
          a_kind = bst_pkg::TK_NEQ;
          a_len  = len_t'(2);
          a_mode = M_START;
        end else begin
          redo = 1'b1;
        end
      end
      M_DASH: begin
        if ((cu == "E") || (cu == "G") || (cu == "L")) begin
          a_dash = (cu == "E") ? bst_pkg::DL_E : ((cu == "G") ? bst_pkg::DL_G : bst_pkg::DL_L);
          a_tlen = len_t'(2);
          a_mode = M_DASH2;
        end else begin
          redo = 1'b1;
        end
      end
      M_DASH2: begin
        if ((cu == "T") || (cu == "Q")) begin
          a_emit = 1'b1;
          a_len  = len_t'(3);
          a_mode = M_START;
          priority if ((dash_q == bst_pkg::DL_E) && (cu == "Q")) begin
            a_kind = bst_pkg::TK_SEQ;
          end else if ((dash_q == bst_pkg::DL_G) && (cu == "T")) begin
            a_kind = bst_pkg::TK_SGTHAN;
          end else if ((dash_q == bst_pkg::DL_L) && (cu == "T")) begin
            a_kind = bst_pkg::TK_SLTHAN;
          end else begin
            a_kind = bst_pkg::TK_MINUS;
          end
        end else begin
          redo = 1'b1;
        end
      end
      default: redo = 1'b1;
    endcase
    // finishing a pending token on a delimiter emits it as a flush would
    if (redo) begin
      a_emit  = fl_emit;
      a_kind  = fl_kind;
      a_start = fl_start;
      a_len   = fl_len;
    end
  end

  // ---------------------------------------------------------------------------
  // next state and results of one transaction
  // ---------------------------------------------------------------------------
  res_t r0, r1;
  logic r0_v, r1_v;

  always_comb begin
    fresh_d  = fresh_q;
    mode_d   = mode_q;
    line_d   = line_q;
    bpos_d   = bpos_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    kwf_d    = kwf_q;
    pfx_d    = pfx_q;
    dash_d   = dash_q;
    r0       = '{kind: fl_kind, line: line0, start: fl_start, len: fl_len, last: 1'b0};
    r1       = '{kind: bst_pkg::TK_DONE, line: line0, start: pos, len: '0, last: 1'b1};
    r0_v     = 1'b0;
    r1_v     = 1'b0;
    if (in_acc) begin
      fresh_d = 1'b0;
      line_d  = line0;
      if (end_of_input_i) begin
        fresh_d = 1'b1;
        mode_d  = M_START;
        bpos_d  = pos;
        r0_v    = fl_emit;
        r1_v    = 1'b1;
      end else begin
        bpos_d = pos + 32'd1;
        r0     = '{kind: a_kind, line: (a_inc ? linc : line0), start: a_start,
                   len: a_len, last: 1'b0};
        r0_v   = a_emit;
        r1     = '{kind: s_kind, line: (s_inc ? linc : line0), start: pos,
                   len: len_t'(1), last: 1'b1};
        r1_v   = redo && s_emit;
        if (a_inc || (redo && s_inc)) begin
          line_d = linc;
        end
        if (redo) begin
          if (!s_keep) begin
            tstart_d = s_tstart;
            tlen_d   = s_tlen;
            kwf_d    = s_kwf;
            pfx_d    = s_pfx;
          end
          mode_d = s_mode;
          dash_d = dash_q;
        end else begin
          mode_d = a_mode;
          tlen_d = a_tlen;
          kwf_d  = a_kwf;
          dash_d = a_dash;
        end
      end
      if (!r1_v) begin
        r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= 1'b1;
      mode_q   <= M_START;
      line_q   <= line_t'(1);
      bpos_q   <= '0;
      tstart_q <= '0;
      tlen_q   <= '0;
      kwf_q    <= 3'b111;
      pfx_q    <= 2'd0;
      dash_q   <= 2'd0;
    end else begin
      fresh_q  <= fresh_d;
      mode_q   <= mode_d;
      line_q   <= line_d;
      bpos_q   <= bpos_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      kwf_q    <= kwf_d;
      pfx_q    <= pfx_d;
      dash_q   <= dash_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  logic [1:0]     push_n;
  logic [QPW-1:0] wr_p1;

  assign out_acc = out_valid_o && out_ready_i;
  assign push_n  = {1'b0, r0_v} + {1'b0, r1_v};
  assign wr_p1   = wr_q + QPW'(1);

  always_ff @(posedge clk_i) begin
    if (r0_v) begin
      q_mem[wr_q] <= r0;
      if (r1_v) begin
        q_mem[wr_p1] <= r1;
      end
    end else if (r1_v) begin
      q_mem[wr_q] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPW'(push_n);
      rd_q  <= rd_q + QPW'(out_acc);
      cnt_q <= cnt_q + QCW'(push_n) - QCW'(out_acc);
    end
  end

  assign out_valid_o     = (cnt_q != '0);
  assign token_kind_o    = q_mem[rd_q].kind;
  assign line_number_o   = q_mem[rd_q].line;
  assign start_offset_o  = q_mem[rd_q].start;
  assign lexeme_length_o = q_mem[rd_q].len;
  assign last_of_run_o   = q_mem[rd_q].last;

endmodule

// File: src/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks for the byte stream tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module bst_checker #(
  parameter int LINE_BITS   = 24,
  parameter int LENGTH_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   end_of_input_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [4:0]             token_kind_o,
  input logic [31:0]            start_offset_o,
  input logic [LENGTH_BITS-1:0] lexeme_length_o,
  input logic                   last_of_run_o
);

  // end of text always yields at least the done token
  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_input_i |=> out_valid_o)
    else $error("no result after end of input");

  // done closes its run and is empty
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == 5'(bst_pkg::TK_DONE))
      |-> last_of_run_o && (lexeme_length_o == '0))
    else $error("done token not last or not empty");

  // input stalls only while results are queued
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result queue");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
      |=> out_valid_o && $stable(token_kind_o) && $stable(start_offset_o))
    else $error("stalled result changed");

endmodule

bind byte_stream_tokenizer_unit bst_checker #(
  .LINE_BITS   (LINE_BITS),
  .LENGTH_BITS (LENGTH_BITS)
) u_bst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .end_of_input_i  (end_of_input_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .token_kind_o    (token_kind_o),
  .start_offset_o  (start_offset_o),
  .lexeme_length_o (lexeme_length_o),
  .last_of_run_o   (last_of_run_o)
);

// File: sim/tb_byte_stream_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_tokenizer_unit
// Feeds source text into the tokenizer as byte transactions and checks every
// token against a cycle-free scanner model kept in the bench. Texts mix
// directed corner cases and random token streams. Both handshake sides idle
// at varying rates, with one long result hold-off, and the line start
// register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_byte_stream_tokenizer_unit;

  localparam int LINE_W = 24;
  localparam int LEN_W  = 16;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [2:0] START_LINE_ADDR = {bst_pkg::REG_START_LINE, 2'b00};
  localparam int HOLD_CYCLES = 400;
  localparam int SHOWN_MAX   = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  typedef struct packed {
    logic [4:0]        kind;
    logic [LINE_W-1:0] line;
    logic [31:0]       offset;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  typedef enum logic [3:0] {
    SM_START, SM_IDENT, SM_STRING, SM_INT, SM_REAL,
    SM_COMMENT, SM_STAR, SM_EQ, SM_DASH, SM_DASH2
  } scan_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         char_byte_i = '0;
  logic               end_of_input_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [4:0]         token_kind_o;
  logic [LINE_W-1:0]  line_number_o;
  logic [31:0]        start_offset_o;
  logic [LEN_W-1:0]   lexeme_length_o;
  logic               last_of_run_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  byte_stream_tokenizer_unit #(
    .LINE_BITS  (LINE_W),
    .LENGTH_BITS(LEN_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .line_number_o  (line_number_o),
    .start_offset_o (start_offset_o),
    .lexeme_length_o(lexeme_length_o),
    .last_of_run_o  (last_of_run_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  src_byte_t pending_bytes[$];
  token_t    step_tokens[$];
  token_t    expected_tokens[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;
  int        hold_done = 0;
  int        hold_left = 0;

  string              kw_words[3] = '{"writeln", "if", "else"};
  bst_pkg::tok_kind_e kw_kinds[3] = '{bst_pkg::TK_WRITELN, bst_pkg::TK_IF, bst_pkg::TK_ELSE};
  string     word_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string     op_chars = "+-*/^><.{}(),;=";

  // scanner state
  scan_mode_e        sm = SM_START;
  logic [LINE_W-1:0] line_cnt = LINE_W'(1);
  logic [31:0]       byte_pos = '0;
  logic [31:0]       tok_start = '0;
  logic [LEN_W-1:0]  tok_len = '0;
  logic [2:0]        kw_match = 3'b111;
  logic [1:0]        id_prefix = 2'd0;
  logic [1:0]        dash_letter = bst_pkg::DL_E;
  logic              text_fresh = 1'b1;
  logic [15:0]       start_line_cfg = 16'd1;

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void bump_line();
    if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
  endfunction

  function automatic void put_token(bst_pkg::tok_kind_e kind, logic [31:0] offset,
                                    logic [LEN_W-1:0] len);
    token_t t;
    t.kind   = kind;
    t.line   = line_cnt;
    t.offset = offset;
    t.len    = len;
    t.last   = 1'b0;
    if (step_tokens.size() < 2) step_tokens.push_back(t);
  endfunction

  function automatic void ident_grow(logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (tok_len >= kw_words[k].len() || kw_words[k][tok_len] != c) kw_match[k] = 1'b0;
    end
    tok_len = len_inc(tok_len);
  endfunction

  function automatic void ident_done();
    for (int k = 0; k < 3; k++) begin
      if (kw_match[k] && tok_len == kw_words[k].len()) begin
        put_token(kw_kinds[k], tok_start, tok_len);
        return;
      end
    end
    put_token(id_prefix == 2'd1 ? bst_pkg::TK_NIDENT :
              (id_prefix == 2'd2 ? bst_pkg::TK_SIDENT : bst_pkg::TK_IDENT),
              tok_start, tok_len);
  endfunction

  function automatic void begin_token(logic [7:0] c, logic [31:0] pos);
    bst_pkg::tok_kind_e kind;
    sm = SM_START;
    if (c == bst_pkg::CH_NL) begin
      bump_line();
      return;
    end
    if (c == bst_pkg::CH_SPACE || c == bst_pkg::CH_TAB) return;
    tok_start = pos;
    tok_len = LEN_W'(1);
    if (c == bst_pkg::CH_QUOTE) begin
      sm = SM_STRING;
      tok_start = pos + 32'd1;
      tok_len = '0;
      return;
    end
    if (c == bst_pkg::CH_HASH) begin
      sm = SM_COMMENT;
      return;
    end
    if (is_num(c)) begin
      sm = SM_INT;
      return;
    end
    if (is_alpha(c) || c == bst_pkg::CH_UNDER || c == bst_pkg::CH_DOLLAR
        || c == bst_pkg::CH_AT) begin
      sm = SM_IDENT;
      id_prefix = (c == bst_pkg::CH_DOLLAR) ? 2'd1 : ((c == bst_pkg::CH_AT) ? 2'd2 : 2'd0);
      kw_match = 3'b111;
      tok_len = '0;
      ident_grow(c);
      return;
    end
    case (c)
      bst_pkg::CH_DASH: begin
        sm = SM_DASH;
        return;
      end
      bst_pkg::CH_STAR: begin
        sm = SM_STAR;
        return;
      end
      bst_pkg::CH_EQ: begin
        sm = SM_EQ;
        return;
      end
      "+": kind = bst_pkg::TK_PLUS;
      "/": kind = bst_pkg::TK_DIV;
      "^": kind = bst_pkg::TK_EXPONENT;
      ">": kind = bst_pkg::TK_NGTHAN;
      "<": kind = bst_pkg::TK_NLTHAN;
      bst_pkg::CH_DOT: kind = bst_pkg::TK_CAT;
      "{": kind = bst_pkg::TK_LBRACES;
      "}": kind = bst_pkg::TK_RBRACES;
      "(": kind = bst_pkg::TK_LPAREN;
      ")": kind = bst_pkg::TK_RPAREN;
      ",": kind = bst_pkg::TK_COMMA;
      ";": kind = bst_pkg::TK_SEMICOL;
      default: begin
        bump_line();
        kind = bst_pkg::TK_ERR;
      end
    endcase
    put_token(kind, pos, LEN_W'(1));
  endfunction

  function automatic void flush_pending();
    case (sm)
      SM_IDENT:  ident_done();
      SM_STRING: put_token(bst_pkg::TK_ERR, tok_start - 32'd1, len_inc(tok_len));
      SM_INT:    put_token(bst_pkg::TK_ICONST, tok_start, tok_len);
      SM_REAL:   put_token(bst_pkg::TK_RCONST, tok_start, tok_len);
      SM_STAR:   put_token(bst_pkg::TK_MULT, tok_start, LEN_W'(1));
      SM_EQ:     put_token(bst_pkg::TK_ASSOP, tok_start, LEN_W'(1));
      SM_DASH:   put_token(bst_pkg::TK_MINUS, tok_start, LEN_W'(1));
      SM_DASH2:  put_token(bst_pkg::TK_MINUS, tok_start, LEN_W'(2));
      default: ;
    endcase
    sm = SM_START;
  endfunction

  function automatic void scan_item(logic [7:0] c, logic eoi);
    logic [31:0]        pos;
    logic [7:0]         u;
    bst_pkg::tok_kind_e kind;
    step_tokens.delete();
    if (text_fresh) begin
      line_cnt = LINE_W'(start_line_cfg);
      byte_pos = '0;
      text_fresh = 1'b0;
    end
    if (eoi) begin
      flush_pending();
      put_token(bst_pkg::TK_DONE, byte_pos, '0);
      text_fresh = 1'b1;
    end else begin
      pos = byte_pos;
      u = upcase(c);
      case (sm)
        SM_IDENT: begin
          if (is_alpha(c) || is_num(c) || c == bst_pkg::CH_UNDER) ident_grow(c);
          else begin
            ident_done();
            begin_token(c, pos);
          end
        end
        SM_STRING: begin
          if (c == bst_pkg::CH_QUOTE) begin
            put_token(bst_pkg::TK_SCONST, tok_start, tok_len);
            sm = SM_START;
          end else if (c == bst_pkg::CH_NL) begin
            bump_line();
            put_token(bst_pkg::TK_ERR, tok_start - 32'd1, len_inc(tok_len));
            sm = SM_START;
          end else tok_len = len_inc(tok_len);
        end
        SM_INT: begin
          if (is_num(c)) tok_len = len_inc(tok_len);
          else if (c == bst_pkg::CH_DOT) begin
            tok_len = len_inc(tok_len);
            sm = SM_REAL;
          end else begin
            put_token(bst_pkg::TK_ICONST, tok_start, tok_len);
            begin_token(c, pos);
          end
        end
        SM_REAL: begin
          if (is_num(c)) tok_len = len_inc(tok_len);
          else if (c == bst_pkg::CH_DOT) begin
            tok_len = len_inc(tok_len);
            bump_line();
            put_token(bst_pkg::TK_ERR, tok_start, tok_len);
            sm = SM_START;
          end else begin
            put_token(bst_pkg::TK_RCONST, tok_start, tok_len);
            begin_token(c, pos);
          end
        end
        SM_COMMENT: begin
          if (c == bst_pkg::CH_NL) begin
            bump_line();
            sm = SM_START;
          end
        end
        SM_STAR: begin
          if (c == bst_pkg::CH_STAR) begin
            put_token(bst_pkg::TK_SREPEAT, tok_start, LEN_W'(2));
            sm = SM_START;
          end else begin
            put_token(bst_pkg::TK_MULT, tok_start, LEN_W'(1));
            begin_token(c, pos);
          end
        end
        SM_EQ: begin
          if (c == bst_pkg::CH_EQ) begin
            put_token(bst_pkg::TK_NEQ, tok_start, LEN_W'(2));
            sm = SM_START;
          end else begin
            put_token(bst_pkg::TK_ASSOP, tok_start, LEN_W'(1));
            begin_token(c, pos);
          end
        end
        SM_DASH: begin
          if (u == "E" || u == "G" || u == "L") begin
            dash_letter = (u == "E") ? bst_pkg::DL_E :
                          ((u == "G") ? bst_pkg::DL_G : bst_pkg::DL_L);
            tok_len = LEN_W'(2);
            sm = SM_DASH2;
          end else begin
            put_token(bst_pkg::TK_MINUS, tok_start, LEN_W'(1));
            begin_token(c, pos);
          end
        end
        SM_DASH2: begin
          if (u == "T" || u == "Q") begin
            kind = bst_pkg::TK_MINUS;
            if (dash_letter == bst_pkg::DL_E && u == "Q") kind = bst_pkg::TK_SEQ;
            else if (dash_letter == bst_pkg::DL_G && u == "T") kind = bst_pkg::TK_SGTHAN;
            else if (dash_letter == bst_pkg::DL_L && u == "T") kind = bst_pkg::TK_SLTHAN;
            put_token(kind, tok_start, LEN_W'(3));
            sm = SM_START;
          end else begin
            put_token(bst_pkg::TK_MINUS, tok_start, LEN_W'(2));
            begin_token(c, pos);
          end
        end
        default: begin_token(c, pos);
      endcase
      byte_pos = pos + 32'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // text generation
  function automatic void push_byte(logic [7:0] b);
    src_byte_t s;
    s.ch  = b;
    s.eoi = 1'b0;
    pending_bytes.push_back(s);
  endfunction

  function automatic void push_str(string txt);
    for (int i = 0; i < txt.len(); i++) push_byte(txt[i]);
  endfunction

  function automatic void push_eoi();
    src_byte_t s;
    s.ch  = 8'($urandom_range(0, 255));
    s.eoi = 1'b1;
    pending_bytes.push_back(s);
  endfunction

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void push_digits(int lo, int hi);
    int n = $urandom_range(lo, hi);
    repeat (n) push_byte(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void push_token();
    int    w;
    string kw;
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0: push_str(kw_words[$urandom_range(0, 2)]);
      1: begin
        kw = kw_words[$urandom_range(0, 2)];
        w = $urandom_range(1, kw.len());
        for (int i = 0; i < w; i++) push_byte(kw[i]);
        if ($urandom_range(0, 1)) push_byte(pick(word_chars));
      end
      2, 3, 18, 19: begin
        push_byte(pick({"$@_", word_chars.substr(0, 51)}));
        repeat ($urandom_range(0, 6)) push_byte(pick(word_chars));
      end
      4: push_digits(1, 5);
      5: begin
        push_digits(1, 3);
        push_byte(bst_pkg::CH_DOT);
        push_digits(0, 3);
      end
      6: begin
        push_digits(1, 2);
        push_byte(bst_pkg::CH_DOT);
        push_digits(0, 2);
        push_byte(bst_pkg::CH_DOT);
      end
      7, 8, 9: begin
        push_byte(bst_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(0, 255));
          if (b == bst_pkg::CH_QUOTE || b == bst_pkg::CH_NL) b = "s";
          push_byte(b);
        end
        push_byte($urandom_range(0, 2) == 0 ? bst_pkg::CH_NL : bst_pkg::CH_QUOTE);
      end
      10, 11: push_byte(pick(op_chars));
      12: push_str($urandom_range(0, 1) ? "**" : "==");
      13, 14: begin
        push_byte(bst_pkg::CH_DASH);
        push_byte(pick("EeGgLlxX1 ;"));
        if ($urandom_range(0, 9) < 7) push_byte(pick("TtQqx("));
      end
      15: begin
        push_byte(bst_pkg::CH_HASH);
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(0, 255));
          push_byte(b == bst_pkg::CH_NL ? bst_pkg::CH_HASH : b);
        end
        push_byte(bst_pkg::CH_NL);
      end
      16: push_byte(8'($urandom_range(0, 255)));
      default: push_byte($urandom_range(0, 1) ? 8'h0d : 8'($urandom_range(128, 255)));
    endcase
  endfunction

  function automatic int push_text();
    int before_len = pending_bytes.size();
    repeat ($urandom_range(1, 25)) begin
      push_token();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4, 5, 6: push_byte(bst_pkg::CH_SPACE);
        7: push_byte(bst_pkg::CH_TAB);
        default: push_byte(bst_pkg::CH_NL);
      endcase
    end
    // sometimes end the text in the middle of a token
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 8))
        0: push_str("'ab");
        1: push_str("#zz");
        2: push_str("*");
        3: push_str("=");
        4: push_str("-");
        5: push_str("-g");
        6: push_str("12");
        7: push_str("3.");
        default: push_str("wr");
      endcase
    end
    push_eoi();
    return pending_bytes.size() - before_len;
  endfunction

  // input driver and predictor hook
  always @(posedge clk_i) begin : drive_proc
    src_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) scan_item(char_byte_i, end_of_input_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          char_byte_i <= nxt.ch;
          end_of_input_i <= nxt.eoi;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long result hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req != hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_req;
    end
  end

  task automatic note_error(string what, token_t want, token_t got);
    error_count++;
    if (error_count <= SHOWN_MAX) begin
      $display("%0t %s: exp kind=%0d line=%0d off=%0d len=%0d last=%0b", $realtime, what,
               want.kind, want.line, want.offset, want.len, want.last);
      $display("%0t %s: got kind=%0d line=%0d off=%0d len=%0d last=%0b", $realtime, what,
               got.kind, got.line, got.offset, got.len, got.last);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin : check_proc
    token_t got;
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind   = token_kind_o;
      got.line   = line_number_o;
      got.offset = start_offset_o;
      got.len    = lexeme_length_o;
      got.last   = last_of_run_o;
      if (expected_tokens.size() == 0) begin
        note_error("unexpected token", '0, got);
      end else begin
        want = expected_tokens.pop_front();
        if (got != want) note_error("token mismatch", want, got);
      end
    end
    out_ready_i <= rst_ni && hold_left == 0 && $urandom_range(0, 99) >= stall_pct;
  end

  task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= START_LINE_ADDR;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_start_line(input logic [15:0] v);
    logic [31:0] rd;
    apb_access(1'b1, {16'h0, v}, rd);
    start_line_cfg = v;
    apb_access(1'b0, '0, rd);
    if (rd != {16'h0, v}) begin
      error_count++;
      if (error_count <= SHOWN_MAX)
        $display("%0t start_line readback: exp %0d got %0d", $realtime, v, rd);
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_tokens.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_random(int n_bytes, int idle, int stall, logic with_hold);
    int pushed = 0;
    @(negedge clk_i);
    send_idle_pct = idle;
    stall_pct = stall;
    while (pushed < n_bytes) pushed += push_text();
    if (with_hold) begin
      repeat (20) @(negedge clk_i);
      hold_req++;
    end
    wait_idle();
  endtask

  initial begin
    logic [31:0] rd;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, '0, rd);
    if (rd != 32'd1) begin
      error_count++;
      $display("%0t start_line after reset: got %0d", $realtime, rd);
    end

    @(negedge clk_i);
    push_str("writeln if\telse $n1 @s_ x9 42 3.25 'ab' '' ** == = * ");
    push_str("-eQ -Gt -lT -et -x -ek 1.2. 'x\n#c\n");
    push_byte(8'h0d);
    push_byte(8'hff);
    push_str("+-*/^><.{}(),;");
    push_eoi();
    push_str("-");
    push_eoi();
    push_str("'ab");
    push_eoi();
    push_str("#c");
    push_eoi();
    push_str("-l");
    push_eoi();
    push_eoi();
    wait_idle();

    set_start_line(16'd0);
    run_random(400, 0, 0, 1'b1);
    set_start_line(16'hffff);
    run_random(380, 68, 0, 1'b0);
    set_start_line(16'($urandom_range(2, 65534)));
    run_random(380, 0, 68, 1'b0);
    set_start_line(16'd1);
    run_random(380, 11, 11, 1'b0);

    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
